FILE: src/itd_pkg.sv
// ----------------------------------------------------------------------------
// itd_pkg: shared types and constants of the tilt dead reckoning block
// Item and result structs, CORDIC control structs, filter gains, CORDIC
// gain corrections and the arctangent table.
// ----------------------------------------------------------------------------
package itd_pkg;

  typedef struct packed {
    logic signed [15:0] accel_x;
    logic signed [15:0] accel_y;
    logic signed [15:0] accel_z;
    logic signed [31:0] odom_position;
  } sample_t;

  typedef struct packed {
    logic signed [15:0] yaw_angle;
    logic        [14:0] slope_angle;
    logic signed [31:0] track_x;
    logic signed [31:0] track_y;
    logic signed [31:0] tilted_y;
    logic signed [31:0] tilted_z;
  } result_t;

  typedef struct packed {
    logic start;
    logic rotate;
  } cordic_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } cordic_stat_t;

  localparam int ATAN_LEN = 24;
  localparam logic [31:0] K_FAST = 32'd6554;
  localparam logic [31:0] K_SLOW = 32'd3277;
  localparam logic [31:0] INV_GAIN_Q30 = 32'd652032874;
  localparam logic [31:0] INV_GAIN_Q20 = 32'd636751;

  function automatic logic [31:0] atan_angle(input logic [4:0] idx);
    logic [31:0] v;
    case (idx)
      5'd0: v = 32'd536870912;
      5'd1: v = 32'd316933406;
      5'd2: v = 32'd167458907;
      5'd3: v = 32'd85004756;
      5'd4: v = 32'd42667331;
      5'd5: v = 32'd21354465;
      5'd6: v = 32'd10679838;
      5'd7: v = 32'd5340245;
      5'd8: v = 32'd2670163;
      5'd9: v = 32'd1335087;
      5'd10: v = 32'd667544;
      5'd11: v = 32'd333772;
      5'd12: v = 32'd166886;
      5'd13: v = 32'd83443;
      5'd14: v = 32'd41722;
      5'd15: v = 32'd20861;
      5'd16: v = 32'd10430;
      5'd17: v = 32'd5215;
      5'd18: v = 32'd2608;
      5'd19: v = 32'd1304;
      5'd20: v = 32'd652;
      5'd21: v = 32'd326;
      5'd22: v = 32'd163;
      5'd23: v = 32'd81;
      default: v = 32'd0;
    endcase
    return v;
  endfunction

endpackage

FILE: src/itd_mul.sv
// ----------------------------------------------------------------------------
// itd_mul: shared signed multiplier
// One signed product per cycle, registered at the output.
// ----------------------------------------------------------------------------
module itd_mul #(
  parameter int AW = 37,
  parameter int BW = 32
) (
  input  logic                    clk,
  input  logic signed [AW-1:0]    a,
  input  logic signed [BW-1:0]    b,
  output logic signed [AW+BW-1:0] p
);

  always_ff @(posedge clk) begin
    p <= a * b;
  end

endmodule

FILE: src/itd_cordic.sv
// ----------------------------------------------------------------------------
// itd_cordic: shared iterative CORDIC unit
// Vectoring mode gives angle and scaled length of (x,y); rotation mode gives
// Q30 cosine and sine of a binary angle. One micro-rotation per cycle.
// ----------------------------------------------------------------------------
module itd_cordic import itd_pkg::*; #(
  parameter int CW = 37,
  parameter int STEPS = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  cordic_req_t          req,
  input  logic signed [CW-1:0] x_in,
  input  logic signed [CW-1:0] y_in,
  input  logic [31:0]          angle_in,
  output logic signed [CW-1:0] x_out,
  output logic signed [CW-1:0] y_out,
  output logic [31:0]          angle_out,
  output cordic_stat_t         stat
);

  localparam int ZW = 34;
  localparam logic signed [CW-1:0] ONE = CW'(signed'(32'h4000_0000));

  logic signed [CW-1:0] x, y, x_next, y_next, shx, shy, cx, cy;
  logic signed [ZW-1:0] z, z_next, at;
  logic [4:0]  cnt;
  logic        busy, done, rotate, zero, neg;
  logic [31:0] fold;

  always_comb begin
    shx = x >>> cnt;
    shy = y >>> cnt;
    at = ZW'(atan_angle(cnt));
    if (rotate) begin
      if (!z[ZW-1]) begin
        x_next = x - shy; y_next = y + shx; z_next = z - at;
      end else begin
        x_next = x + shy; y_next = y - shx; z_next = z + at;
      end
    end else begin
      if (!y[CW-1]) begin
        x_next = x + shy; y_next = y - shx; z_next = z + at;
      end else begin
        x_next = x - shy; y_next = y + shx; z_next = z - at;
      end
    end
    if (angle_in >= 32'h4000_0000 && angle_in < 32'hC000_0000) begin
      fold = angle_in - 32'h8000_0000;
    end else begin
      fold = angle_in;
    end
    cx = (x > ONE) ? ONE : ((x < -ONE) ? -ONE : x);
    cy = (y > ONE) ? ONE : ((y < -ONE) ? -ONE : y);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt <= '0;
        rotate <= req.rotate;
        if (req.rotate) begin
          x <= CW'(signed'(INV_GAIN_Q30));
          y <= '0;
          z <= ZW'(signed'(fold));
          neg <= (fold != angle_in);
          zero <= 1'b0;
        end else begin
          zero <= (x_in == '0) && (y_in == '0);
          neg <= 1'b0;
          if (x_in[CW-1]) begin
            x <= -x_in; y <= -y_in; z <= ZW'(33'h0_8000_0000);
          end else begin
            x <= x_in; y <= y_in; z <= '0;
          end
        end
      end else if (busy) begin
        x <= x_next;
        y <= y_next;
        z <= z_next;
        cnt <= cnt + 5'd1;
        if (cnt == 5'(STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_comb begin
    if (rotate) begin
      x_out = neg ? -cx : cx;
      y_out = neg ? -cy : cy;
    end else begin
      x_out = zero ? '0 : x;
      y_out = zero ? '0 : y;
    end
    angle_out = zero ? 32'd0 : z[31:0];
    stat.busy = busy;
    stat.done = done;
  end

endmodule

FILE: src/imu_tilt_dead_reckoning_top.sv
// ----------------------------------------------------------------------------
// imu_tilt_dead_reckoning_top: tilt-compensated dead reckoning
// Gravity low-pass filters, yaw and slope by CORDIC, planar odometer track
// and its rotation about the x axis by the slope.
//
//   channel  | direction | valid / stall              | payload
//   sample   | in        | sample_valid/sample_stall  | sample (sample_t)
//   result   | out       | result_valid/result_stall  | result (result_t)
//
// The five CORDIC passes run through one shared unit, each of STEPS
// micro-rotations, where STEPS is CORDIC_STEPS capped at 24. Six filter
// updates and five further products, eleven products in all, share one
// multiplier. The idle state takes the sample and the done state loads the
// result.
// Reset is synchronous and clears all filter, origin and track state.
// A new sample is taken only when the sequencer is idle; a finished result
// waits in the output register while result_stall is high.
// ----------------------------------------------------------------------------
module imu_tilt_dead_reckoning_top import itd_pkg::*; #(
  parameter int ANGLE_BITS = 16,
  parameter int FILTER_FRAC_BITS = 8,
  parameter int CORDIC_STEPS = 16
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    sample_valid,
  output logic    sample_stall,
  input  sample_t sample,
  output logic    result_valid,
  input  logic    result_stall,
  output result_t result
);

  localparam int AB = ANGLE_BITS;
  localparam int FFB = FILTER_FRAC_BITS;
  localparam int STEPS = (CORDIC_STEPS > ATAN_LEN) ? ATAN_LEN : CORDIC_STEPS;
  localparam int GW = 16 + FFB;
  localparam int CW = GW + 13;
  localparam int MW = CW + 32;

  typedef enum logic [4:0] {
    S_IDLE, S_FILT_MUL, S_FILT_ACC, S_YAW_GO, S_YAW_WAIT, S_HEAD_GO, S_HEAD_WAIT,
    S_PX_MUL, S_PX_ACC, S_PY_MUL, S_PY_ACC, S_MAG_GO, S_MAG_WAIT, S_R_MUL, S_R_ACC,
    S_SLOPE_GO, S_SLOPE_WAIT, S_TILT_GO, S_TILT_WAIT, S_TY_MUL, S_TY_ACC,
    S_TZ_MUL, S_TZ_ACC, S_DONE
  } state_t;

  state_t state;
  sample_t item;
  logic signed [GW-1:0] grav [6];
  logic [2:0] fidx;
  logic signed [31:0] odom_origin, last_relative_odom, pos_x, pos_y, ty, tz;
  logic [AB-1:0] yaw_origin, rel_yaw, slope_q;
  logic started;
  logic signed [32:0] dx;
  logic signed [CW-1:0] r;

  cordic_req_t creq;
  cordic_stat_t cstat;
  logic signed [CW-1:0] cx_in, cy_in, cx_out, cy_out;
  logic [31:0] cangle_in, cangle_out;
  logic signed [CW-1:0] ma;
  logic signed [31:0] mb;
  logic signed [MW-1:0] mp, rnd30;

  logic signed [15:0] acc_sel;
  logic signed [GW:0] d;
  logic [AB-1:0] yaw_q, yo_use, slope_next;
  logic signed [31:0] origin_use, rel;
  logic signed [32:0] rel33;
  logic [31:0] s32;
  logic [15:0] slope16;

  function automatic logic signed [31:0] sat32(input logic signed [MW-1:0] v);
    logic signed [31:0] o;
    if (v > MW'(signed'(32'h7FFF_FFFF))) o = 32'sh7FFF_FFFF;
    else if (v < MW'(signed'(32'h8000_0000))) o = 32'sh8000_0000;
    else o = v[31:0];
    return o;
  endfunction

  function automatic logic [AB-1:0] quant(input logic [31:0] a);
    logic [31:0] s;
    s = a + (32'd1 << (31 - AB));
    return s[31:32-AB];
  endfunction

  function automatic logic [31:0] widen(input logic [AB-1:0] q);
    return 32'({q, {(32 - AB){1'b0}}});
  endfunction

  function automatic logic [15:0] to16(input logic [AB-1:0] q);
    logic [31:0] w;
    w = widen(q);
    return w[31:16];
  endfunction

  itd_cordic #(.CW(CW), .STEPS(STEPS)) u_cordic (
    .clk(clk), .rst(rst), .req(creq), .x_in(cx_in), .y_in(cy_in),
    .angle_in(cangle_in), .x_out(cx_out), .y_out(cy_out),
    .angle_out(cangle_out), .stat(cstat)
  );

  itd_mul #(.AW(CW), .BW(32)) u_mul (.clk(clk), .a(ma), .b(mb), .p(mp));

  always_comb begin
    case (fidx)
      3'd0, 3'd3: acc_sel = item.accel_x;
      3'd1, 3'd4: acc_sel = item.accel_y;
      default: acc_sel = item.accel_z;
    endcase
    d = $signed({acc_sel[15], acc_sel, {FFB{1'b0}}}) - (GW + 1)'(grav[fidx]);
    rnd30 = (mp + MW'(signed'(32'h2000_0000))) >>> 30;

    creq.start = (state == S_YAW_GO) || (state == S_HEAD_GO) || (state == S_MAG_GO) ||
                 (state == S_SLOPE_GO) || (state == S_TILT_GO);
    creq.rotate = (state == S_HEAD_GO) || (state == S_TILT_GO);
    cangle_in = (state == S_TILT_GO) ? widen(slope_q) : widen(rel_yaw);
    case (state)
      S_YAW_GO: begin
        cx_in = CW'($signed({grav[2], 8'd0}));
        cy_in = CW'($signed({grav[1], 8'd0}));
      end
      S_MAG_GO: begin
        cx_in = CW'($signed({grav[5], 8'd0}));
        cy_in = CW'($signed({grav[4], 8'd0}));
      end
      S_SLOPE_GO: begin
        cx_in = CW'($signed({grav[3], 8'd0}));
        cy_in = r;
      end
      default: begin
        cx_in = '0;
        cy_in = '0;
      end
    endcase

    case (state)
      S_FILT_MUL: begin
        ma = CW'(d);
        mb = (fidx < 3'd3) ? K_FAST : K_SLOW;
      end
      S_PX_MUL: begin ma = CW'(dx); mb = cx_out[31:0]; end
      S_PY_MUL: begin ma = CW'(dx); mb = cy_out[31:0]; end
      S_R_MUL: begin ma = cx_out; mb = INV_GAIN_Q20; end
      S_TY_MUL: begin ma = CW'(pos_y); mb = cx_out[31:0]; end
      S_TZ_MUL: begin ma = CW'(pos_y); mb = cy_out[31:0]; end
      default: begin ma = '0; mb = '0; end
    endcase

    yaw_q = quant(cangle_out);
    origin_use = started ? odom_origin : item.odom_position;
    yo_use = started ? yaw_origin : yaw_q;
    rel33 = 33'(item.odom_position) - 33'(origin_use);
    if (rel33 > 33'sh0_7FFF_FFFF) rel = 32'sh7FFF_FFFF;
    else if (rel33 < -33'sh0_8000_0000) rel = 32'sh8000_0000;
    else rel = rel33[31:0];

    if (cangle_out >= 32'hC000_0000) s32 = 32'd0;
    else if (cangle_out > 32'h8000_0000) s32 = 32'h8000_0000;
    else s32 = cangle_out;
    slope_next = quant(s32);
    slope16 = to16(slope_q);
    sample_stall = (state != S_IDLE);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      result_valid <= 1'b0;
      started <= 1'b0;
      fidx <= '0;
      for (int i = 0; i < 6; i++) grav[i] <= '0;
      odom_origin <= '0;
      last_relative_odom <= '0;
      yaw_origin <= '0;
      pos_x <= '0;
      pos_y <= '0;
    end else begin
      if (result_valid && !result_stall && state != S_DONE) result_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (sample_valid) begin
            item <= sample;
            fidx <= '0;
            state <= S_FILT_MUL;
          end
        end
        S_FILT_MUL: state <= S_FILT_ACC;
        S_FILT_ACC: begin
          grav[fidx] <= grav[fidx] + GW'((mp + MW'(32768)) >>> 16);
          fidx <= fidx + 3'd1;
          state <= (fidx == 3'd5) ? S_YAW_GO : S_FILT_MUL;
        end
        S_YAW_GO: state <= S_YAW_WAIT;
        S_YAW_WAIT: begin
          if (cstat.done) begin
            odom_origin <= origin_use;
            yaw_origin <= yo_use;
            started <= 1'b1;
            last_relative_odom <= rel;
            dx <= 33'(rel) - 33'(started ? last_relative_odom : 32'sd0);
            rel_yaw <= yaw_q - yo_use;
            state <= S_HEAD_GO;
          end
        end
        S_HEAD_GO: state <= S_HEAD_WAIT;
        S_HEAD_WAIT: if (cstat.done) state <= S_PX_MUL;
        S_PX_MUL: state <= S_PX_ACC;
        S_PX_ACC: begin
          pos_x <= sat32(MW'(pos_x) + rnd30);
          state <= S_PY_MUL;
        end
        S_PY_MUL: state <= S_PY_ACC;
        S_PY_ACC: begin
          pos_y <= sat32(MW'(pos_y) + rnd30);
          state <= S_MAG_GO;
        end
        S_MAG_GO: state <= S_MAG_WAIT;
        S_MAG_WAIT: if (cstat.done) state <= S_R_MUL;
        S_R_MUL: state <= S_R_ACC;
        S_R_ACC: begin
          r <= CW'((mp + MW'(524288)) >>> 20);
          state <= S_SLOPE_GO;
        end
        S_SLOPE_GO: state <= S_SLOPE_WAIT;
        S_SLOPE_WAIT: begin
          if (cstat.done) begin
            slope_q <= slope_next;
            state <= S_TILT_GO;
          end
        end
        S_TILT_GO: state <= S_TILT_WAIT;
        S_TILT_WAIT: if (cstat.done) state <= S_TY_MUL;
        S_TY_MUL: state <= S_TY_ACC;
        S_TY_ACC: begin
          ty <= sat32(rnd30);
          state <= S_TZ_MUL;
        end
        S_TZ_MUL: state <= S_TZ_ACC;
        S_TZ_ACC: begin
          tz <= sat32(rnd30);
          state <= S_DONE;
        end
        S_DONE: begin
          if (!result_valid || !result_stall) begin
            result.yaw_angle <= to16(rel_yaw);
            result.slope_angle <= slope16[15] ? 15'h7FFF : slope16[14:0];
            result.track_x <= pos_x;
            result.track_y <= pos_y;
            result.tilted_y <= ty;
            result.tilted_z <= tz;
            result_valid <= 1'b1;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_cordic_idle_start: assert property (@(posedge clk) disable iff (rst)
    creq.start |-> !cstat.busy) else $error("CORDIC started while busy");

  a_done_holds: assert property (@(posedge clk) disable iff (rst)
    (state == S_DONE && result_valid && result_stall) |=> state == S_DONE)
    else $error("Result overwritten while the output register is full");

  a_px_product: assert property (@(posedge clk) disable iff (rst)
    state == S_PX_MUL |=> state == S_PX_ACC)
    else $error("Track x update without its product");

  a_filter_index: assert property (@(posedge clk) disable iff (rst)
    (state == S_FILT_MUL || state == S_FILT_ACC) |-> fidx < 3'd6)
    else $error("Filter index out of range");

endmodule

FILE: tb/imu_tilt_dead_reckoning_top_tb.sv
// ----------------------------------------------------------------------------
// imu_tilt_dead_reckoning_top_tb: self-checking bench for the tilt dead
// reckoning block
// A directed table covers reset state, field extremes, the zero vector,
// slope ends and odometer saturation. Random samples follow, mostly smooth
// sensor walks with occasional jumps. Each result is compared as a whole
// with a bit-exact fixed-point predictor, under random bursts and stalls.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module imu_tilt_dead_reckoning_top_tb;
  import itd_pkg::*;

  localparam int N_RANDOM = 1530;
  localparam int WATCHDOG_LIMIT = 20000;

  logic    clk;
  logic    rst;
  logic    sample_valid;
  logic    sample_stall;
  sample_t sample;
  logic    result_valid;
  logic    result_stall;
  result_t result;

  imu_tilt_dead_reckoning_top i_dut (
    .clk(clk),
    .rst(rst),
    .sample_valid(sample_valid),
    .sample_stall(sample_stall),
    .sample(sample),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .result(result)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Predictor state.
  longint fgx, fgy, fgz, sgx, sgy, sgz;
  longint odom_org, last_rel, px, py;
  logic [31:0] yaw_org;
  bit started;

  result_t expected_q[$];
  int mismatches = 0;
  int checked = 0;
  int watchdog = 0;
  bit timed_out;

  function automatic longint sat32(input longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint lowpass(input longint g, input longint a, input longint k);
    longint d;
    d = (a <<< 8) - g;
    return g + ((d * k + 32768) >>> 16);
  endfunction

  function automatic logic [31:0] vectoring(input longint x, input longint y,
                                            output longint len);
    logic [31:0] z;
    longint dx, dy;
    z = 0;
    if (x == 0 && y == 0) begin
      len = 0;
      return 0;
    end
    if (x < 0) begin
      x = -x;
      y = -y;
      z = 32'h8000_0000;
    end
    for (int i = 0; i < 16; i++) begin
      dx = x >>> i;
      dy = y >>> i;
      if (y >= 0) begin
        x += dy; y -= dx; z += atan_angle(i[4:0]);
      end else begin
        x -= dy; y += dx; z -= atan_angle(i[4:0]);
      end
    end
    len = x;
    return z;
  endfunction

  function automatic longint clamp_unit(input longint v);
    if (v > (64'sd1 << 30)) return 64'sd1 << 30;
    if (v < -(64'sd1 << 30)) return -(64'sd1 << 30);
    return v;
  endfunction

  function automatic void sincos(input logic [31:0] a, output longint c, output longint s);
    bit neg;
    longint x, y, z, dx, dy;
    neg = 0;
    x = 652032874;
    y = 0;
    if (a >= 32'h4000_0000 && a < 32'hC000_0000) begin
      a -= 32'h8000_0000;
      neg = 1;
    end
    z = longint'($signed(a));
    for (int i = 0; i < 16; i++) begin
      dx = x >>> i;
      dy = y >>> i;
      if (z >= 0) begin
        x -= dy; y += dx; z -= longint'(atan_angle(i[4:0]));
      end else begin
        x += dy; y -= dx; z += longint'(atan_angle(i[4:0]));
      end
    end
    x = clamp_unit(x);
    y = clamp_unit(y);
    c = neg ? -x : x;
    s = neg ? -y : y;
  endfunction

  function automatic logic [15:0] quant(input logic [31:0] a);
    logic [32:0] r;
    r = {1'b0, a} + 33'h8000;
    return r[31:16];
  endfunction

  function automatic result_t track_step(input sample_t smp);
    result_t r;
    longint len, mag, rel, dx, c, s;
    logic [15:0] yaw_q, rel_yaw, slope_q;
    logic [31:0] s32;
    fgx = lowpass(fgx, smp.accel_x, 6554);
    fgy = lowpass(fgy, smp.accel_y, 6554);
    fgz = lowpass(fgz, smp.accel_z, 6554);
    sgx = lowpass(sgx, smp.accel_x, 3277);
    sgy = lowpass(sgy, smp.accel_y, 3277);
    sgz = lowpass(sgz, smp.accel_z, 3277);
    yaw_q = quant(vectoring(fgz * 256, fgy * 256, len));
    if (!started) begin
      odom_org = smp.odom_position;
      last_rel = 0;
      yaw_org = yaw_q;
      started = 1;
    end
    rel = sat32(longint'(smp.odom_position) - odom_org);
    dx = rel - last_rel;
    last_rel = rel;
    rel_yaw = yaw_q - yaw_org[15:0];
    sincos({rel_yaw, 16'h0}, c, s);
    px = sat32(px + ((dx * c + (64'sd1 << 29)) >>> 30));
    py = sat32(py + ((dx * s + (64'sd1 << 29)) >>> 30));
    s32 = vectoring(sgz * 256, sgy * 256, len);
    mag = (len * 636751 + (64'sd1 << 19)) >>> 20;
    s32 = vectoring(sgx * 256, mag, len);
    if (s32 >= 32'hC000_0000) s32 = 0;
    else if (s32 > 32'h8000_0000) s32 = 32'h8000_0000;
    slope_q = quant(s32);
    sincos({slope_q, 16'h0}, c, s);
    r.yaw_angle = rel_yaw;
    r.slope_angle = (slope_q > 16'd32767) ? 15'h7FFF : slope_q[14:0];
    r.track_x = px[31:0];
    r.track_y = py[31:0];
    r.tilted_y = sat32((py * c + (64'sd1 << 29)) >>> 30);
    r.tilted_z = sat32((py * s + (64'sd1 << 29)) >>> 30);
    return r;
  endfunction

  // Directed rows: a known expectation is given where it is obvious.
  typedef struct {
    sample_t smp;
    bit      known;
    result_t res;
  } row_t;

  row_t rows[$];

  function automatic sample_t mk(input int ax, input int ay, input int az, input int od);
    sample_t s;
    s.accel_x = ax[15:0];
    s.accel_y = ay[15:0];
    s.accel_z = az[15:0];
    s.odom_position = od;
    return s;
  endfunction

  task automatic add_row(input sample_t s, input bit known, input result_t r);
    row_t w;
    w.smp = s;
    w.known = known;
    w.res = r;
    rows = {rows, w};
  endtask

  task automatic queue_expected(input result_t r);
    expected_q = {expected_q, r};
  endtask

  task automatic send(input sample_t s);
    sample <= s;
    sample_valid <= 1'b1;
    @(posedge clk);
    while (sample_stall) @(posedge clk);
  endtask

  // Result side: stall pattern and checking.
  int stall_mode = 1;
  always @(posedge clk) begin
    if (rst) begin
      result_stall <= 1'b0;
    end else begin
      case (stall_mode)
        0: result_stall <= 1'b0;
        1: result_stall <= ($urandom_range(0, 3) == 0);
        default: result_stall <= ($urandom_range(0, 9) < 7);
      endcase
      if ($urandom_range(0, 199) == 0) stall_mode <= $urandom_range(0, 2);
    end
  end

  always @(posedge clk) begin
    result_t e;
    if (!rst) begin
      if ((sample_valid && !sample_stall) || (result_valid && !result_stall)) watchdog <= 0;
      else watchdog <= watchdog + 1;
      if (result_valid && !result_stall) begin
        checked++;
        if (expected_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result transfer: %p", result);
        end else begin
          e = expected_q.pop_front();
          if (result !== e) begin
            mismatches++;
            if (mismatches <= 10) $display("mismatch: expected %p, got %p", e, result);
          end
        end
      end
    end
  end

  initial begin
    wait (watchdog >= WATCHDOG_LIMIT);
    $display("watchdog expired with %0d results pending", expected_q.size());
    $display("tb: failure");
    $finish;
  end

  initial begin
    result_t r0;
    sample_t s;
    int ax, ay, az, od, burst;
    rst = 1'b1;
    sample_valid = 1'b0;
    sample = '0;
    fgx = 0; fgy = 0; fgz = 0; sgx = 0; sgy = 0; sgz = 0;
    odom_org = 0; last_rel = 0; px = 0; py = 0; yaw_org = 0; started = 0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // First item is the zero vector: every angle and the track stay zero.
    r0 = '0;
    add_row(mk(0, 0, 0, 12345), 1, r0);
    add_row(mk(0, 0, 0, 12345), 1, r0);
    add_row(mk(32767, 0, 0, 32'h0001_0000), 0, r0);
    add_row(mk(-32768, 0, 0, 32'h0002_0000), 0, r0);
    add_row(mk(-32768, 0, 0, 32'h0003_0000), 0, r0);
    add_row(mk(0, 32767, 0, 32'h7FFF_FFFF), 0, r0);
    add_row(mk(0, -32768, 32767, 32'h8000_0000), 0, r0);
    add_row(mk(0, 0, -32768, 32'h7FFF_FFFF), 0, r0);
    add_row(mk(0, 0, 32767, 32'h8000_0000), 0, r0);
    add_row(mk(-1, -1, -1, -1), 0, r0);
    add_row(mk(32767, 32767, 32767, 0), 0, r0);
    add_row(mk(-32768, -32768, -32768, 32'h4000_0000), 0, r0);
    for (int i = 0; i < 8; i++)
      add_row(mk(0, 20000, 20000, 32'h7000_0000 + i * 32'h1000_0000), 0, r0);

    foreach (rows[i]) begin
      if (rows[i].known) begin
        void'(track_step(rows[i].smp));
        queue_expected(rows[i].res);
      end else begin
        queue_expected(track_step(rows[i].smp));
      end
      send(rows[i].smp);
    end

    ax = 0; ay = 0; az = 16000; od = 0;
    for (int n = 0; n < N_RANDOM; ) begin
      burst = $urandom_range(1, 40);
      for (int b = 0; b < burst && n < N_RANDOM; b++, n++) begin
        if ($urandom_range(0, 9) == 0) begin
          s = sample_t'(80'({$urandom, $urandom, $urandom}));
        end else begin
          ax = ax + $signed($urandom_range(0, 4000)) - 2000;
          ay = ay + $signed($urandom_range(0, 4000)) - 2000;
          az = az + $signed($urandom_range(0, 4000)) - 2000;
          if (ax > 32767) ax = 32767; if (ax < -32768) ax = -32768;
          if (ay > 32767) ay = 32767; if (ay < -32768) ay = -32768;
          if (az > 32767) az = 32767; if (az < -32768) az = -32768;
          od = od + $signed($urandom_range(0, 400000)) - 100000;
          s = mk(ax, ay, az, od);
        end
        queue_expected(track_step(s));
        send(s);
      end
      sample_valid <= 1'b0;
      repeat ($urandom_range(0, 300)) @(posedge clk);
    end
    sample_valid <= 1'b0;

    while (expected_q.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    $display("covered %0d directed and %0d random samples, %0d results checked",
             rows.size(), N_RANDOM, checked);
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("tb: failure");
    end
    $finish;
  end

endmodule
